// ===== rtl/rrcs_pkg.sv =====
// Shared types and constants for the run-length to clipped row span block.
// Used by rrcs_ctrl, rrcs_dp and the top level; depends on nothing.
`default_nettype none

package rrcs_pkg;

  localparam int unsigned RUN_LEN_W  = 15;
  localparam int unsigned COLOR_W    = 16;
  localparam int unsigned CFG_W      = 9;
  localparam int unsigned SPAN_W     = 9;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned S_TDATA_W  = 32;
  localparam int unsigned M_TDATA_W  = 48;

  localparam logic [CNT_W-1:0] MAX_SPANS = 6'd63;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_WIN_X = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WIN_Y = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WIN_W = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_WIN_H = 2'd3;

  localparam logic [CFG_W-1:0] WIN_X_RST = 9'd0;
  localparam logic [CFG_W-1:0] WIN_Y_RST = 9'd0;
  localparam logic [CFG_W-1:0] WIN_W_RST = 9'd480;
  localparam logic [CFG_W-1:0] WIN_H_RST = 9'd320;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // take a new run
    logic step;       // consume one row segment
    logic push_pend;  // pending span to the output register
    logic push_new;   // span of this step straight to the output register
    logic push_last;  // pushed span closes the run
    logic pend_wr;    // span of this step into the pending register
    logic pend_clr;   // pending register emptied
    logic finish;     // run complete, home the position on last_run
  } rrcs_cmd_t;

  // status from the datapath
  typedef struct packed {
    logic new_span;   // this step yields a visible span
    logic done;       // this step ends the run
    logic pend_vld;
    logic out_free;
  } rrcs_stat_t;

endpackage

`default_nettype wire

// ===== rtl/rrcs_ctrl.sv =====
// Controller of the span splitter: sequences load, row steps and the flush
// of the held-back span. Depends on rrcs_pkg.
`default_nettype none

module rrcs_ctrl import rrcs_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire rrcs_stat_t stat_i,
  output rrcs_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_STEP  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   need_push;

  // a span leaves for the output when a newer one replaces it or the run ends
  assign need_push = (stat_i.pend_vld && (stat_i.new_span || stat_i.done)) ||
                     (!stat_i.pend_vld && stat_i.new_span && stat_i.done);

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_STEP;
        end
      end
      ST_STEP: begin
        if (!need_push || stat_i.out_free) begin
          cmd_o.step      = 1'b1;
          cmd_o.push_pend = stat_i.pend_vld && (stat_i.new_span || stat_i.done);
          cmd_o.push_new  = !stat_i.pend_vld && stat_i.new_span && stat_i.done;
          cmd_o.push_last = stat_i.done && (!stat_i.new_span || !stat_i.pend_vld);
          cmd_o.pend_wr   = stat_i.new_span && !cmd_o.push_new;
          cmd_o.pend_clr  = cmd_o.push_pend && !stat_i.new_span;
          if (stat_i.done) begin
            if (cmd_o.pend_wr) begin
              state_d = ST_FLUSH;
            end else begin
              cmd_o.finish = 1'b1;
              state_d      = ST_IDLE;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (stat_i.out_free) begin
          cmd_o.push_pend = 1'b1;
          cmd_o.push_last = 1'b1;
          cmd_o.pend_clr  = 1'b1;
          cmd_o.finish    = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rrcs_dp.sv =====
// Datapath of the span splitter: window registers, raster position, row
// segment arithmetic, pending span and output register. Depends on rrcs_pkg.
`default_nettype none

module rrcs_dp import rrcs_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 480,
  parameter int unsigned SCREEN_HEIGHT = 320
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_we_i,
  input  wire  [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire  [CFG_W-1:0]       cfg_data_i,
  input  wire  [RUN_LEN_W-1:0]   run_length_i,
  input  wire  [COLOR_W-1:0]     run_color_i,
  input  wire                    last_run_i,
  input  wire rrcs_cmd_t         cmd_i,
  output rrcs_stat_t             stat_o,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output logic [M_TDATA_W-1:0]   out_data_o,
  output logic                   out_last_o
);

  localparam int unsigned COL_W = $clog2(SCREEN_WIDTH + 1);
  localparam int unsigned ROW_W = $clog2(SCREEN_HEIGHT + 1);
  localparam int unsigned XW    = (COL_W > CFG_W + 1) ? COL_W : CFG_W + 1;
  localparam int unsigned YW    = (ROW_W > CFG_W + 1) ? ROW_W : CFG_W + 1;
  localparam int unsigned LW    = (COL_W > RUN_LEN_W) ? COL_W : RUN_LEN_W;
  localparam int unsigned PAD_W = M_TDATA_W - 3 * SPAN_W - COLOR_W;

  // configuration
  logic [CFG_W-1:0] win_x_q, win_y_q, win_w_q, win_h_q;

  // run state
  logic [COL_W-1:0]     col_q, x0_q, x1_q;
  logic [ROW_W-1:0]     row_q, y0_q, y1_q;
  logic [RUN_LEN_W-1:0] pl_q;
  logic [COLOR_W-1:0]   color_q;
  logic                 last_q, vis_q;
  logic [CNT_W-1:0]     n_q;

  // pending span and output register
  logic              pend_vld_q;
  logic [SPAN_W-1:0] pend_x_q, pend_y_q, pend_len_q;
  logic              out_vld_q, out_last_q;
  logic [SPAN_W-1:0] out_x_q, out_y_q, out_len_q;
  logic [COLOR_W-1:0] out_color_q;

  // window set-up
  logic [XW-1:0] wx, wx_end, x_end;
  logic [YW-1:0] wy, wy_end, y_end;
  logic          win_vis;

  always_comb begin
    wx      = XW'(win_x_q);
    wy      = YW'(win_y_q);
    wx_end  = wx + XW'(win_w_q);
    wy_end  = wy + YW'(win_h_q);
    x_end   = (wx_end > XW'(SCREEN_WIDTH))  ? XW'(SCREEN_WIDTH)  : wx_end;
    y_end   = (wy_end > YW'(SCREEN_HEIGHT)) ? YW'(SCREEN_HEIGHT) : wy_end;
    win_vis = (wx < XW'(SCREEN_WIDTH)) && (wy < YW'(SCREEN_HEIGHT)) &&
              (win_w_q != '0) && (win_h_q != '0);
  end

  // one row segment
  logic [LW-1:0]        room_l, pl_l, seg_l;
  logic [COL_W-1:0]     seg, col_sum, sp_s, sp_e, sp_len;
  logic [RUN_LEN_W-1:0] pl_next;
  logic [ROW_W-1:0]     row_inc;
  logic                 active, wrap, done, row_in, new_span;

  always_comb begin
    active   = (pl_q != '0) && (row_q < ROW_W'(SCREEN_HEIGHT));
    room_l   = LW'(SCREEN_WIDTH) - LW'(col_q);
    pl_l     = LW'(pl_q);
    seg_l    = (pl_l < room_l) ? pl_l : room_l;
    seg      = COL_W'(seg_l);
    col_sum  = col_q + seg;
    pl_next  = pl_q - RUN_LEN_W'(seg_l);
    wrap     = (col_sum == COL_W'(SCREEN_WIDTH));
    row_inc  = row_q + 1'b1;
    done     = !active || (pl_next == '0) ||
               (wrap && (row_inc == ROW_W'(SCREEN_HEIGHT)));
    sp_s     = (col_q > x0_q) ? col_q : x0_q;
    sp_e     = (col_sum < x1_q) ? col_sum : x1_q;
    sp_len   = sp_e - sp_s;
    row_in   = (row_q >= y0_q) && (row_q < y1_q);
    new_span = active && vis_q && row_in && (sp_e > sp_s) && (n_q != MAX_SPANS);
  end

  assign stat_o.new_span = new_span;
  assign stat_o.done     = done;
  assign stat_o.pend_vld = pend_vld_q;
  assign stat_o.out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_x_q <= WIN_X_RST;
      win_y_q <= WIN_Y_RST;
      win_w_q <= WIN_W_RST;
      win_h_q <= WIN_H_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_WIN_X: win_x_q <= cfg_data_i;
        REG_WIN_Y: win_y_q <= cfg_data_i;
        REG_WIN_W: win_w_q <= cfg_data_i;
        REG_WIN_H: win_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      pl_q       <= '0;
      n_q        <= '0;
      last_q     <= 1'b0;
      vis_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        pl_q   <= run_length_i;
        n_q    <= '0;
        last_q <= last_run_i;
        vis_q  <= win_vis;
      end else if (cmd_i.step && active) begin
        pl_q <= pl_next;
        if (wrap) begin
          col_q <= '0;
          row_q <= row_inc;
        end else begin
          col_q <= col_sum;
        end
        if (new_span) begin
          n_q <= n_q + 1'b1;
        end
      end else if (cmd_i.step) begin
        // empty run or screen used up: the run is dropped
        pl_q <= '0;
      end
      if (cmd_i.finish && last_q) begin
        col_q <= '0;
        row_q <= '0;
      end
      if (cmd_i.pend_wr) begin
        pend_vld_q <= 1'b1;
      end else if (cmd_i.pend_clr) begin
        pend_vld_q <= 1'b0;
      end
      if (cmd_i.push_pend || cmd_i.push_new) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      color_q <= run_color_i;
      x0_q    <= COL_W'(wx);
      x1_q    <= COL_W'(x_end);
      y0_q    <= ROW_W'(wy);
      y1_q    <= ROW_W'(y_end);
    end
    if (cmd_i.pend_wr) begin
      pend_x_q   <= SPAN_W'(sp_s);
      pend_y_q   <= SPAN_W'(row_q);
      pend_len_q <= SPAN_W'(sp_len);
    end
    if (cmd_i.push_pend) begin
      out_x_q   <= pend_x_q;
      out_y_q   <= pend_y_q;
      out_len_q <= pend_len_q;
    end else if (cmd_i.push_new) begin
      out_x_q   <= SPAN_W'(sp_s);
      out_y_q   <= SPAN_W'(row_q);
      out_len_q <= SPAN_W'(sp_len);
    end
    if (cmd_i.push_pend || cmd_i.push_new) begin
      out_color_q <= color_q;
      out_last_q  <= cmd_i.push_last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = {PAD_W'(0), out_color_q, out_len_q, out_y_q, out_x_q};
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/rle_runs_to_clipped_row_spans_core.sv =====
// Top level of the run-length to clipped row span block: stream ports,
// configuration port, controller and datapath. Depends on rrcs_pkg,
// rrcs_ctrl and rrcs_dp.
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+------------------------------
//  s_axis    | in        | tvalid / tready           | tdata: length, colour; tlast: last run
//  m_axis    | out       | tvalid / tready           | tdata: x, y, length, colour; tlast
//  cfg       | in        | cfg_valid_i / cfg_ready_o | cfg_addr_i, cfg_data_i
//
//  A run is accepted in ST_IDLE, then walks one row segment per step in ST_STEP (a
//  single step for an empty or dropped run), and passes through ST_FLUSH when its final
//  segment yields a span while an earlier span is still held. The next run is accepted
//  only back in ST_IDLE. Each step uses the single row-segment adder/comparator path.
//  Output stalls hold the segment step only when a span must move into an occupied
//  output register. Reset restores the 480 x 320 window at (0, 0) and the origin; cfg is
//  always ready.
`default_nettype none

module rle_runs_to_clipped_row_spans_core import rrcs_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 480,
  parameter int unsigned SCREEN_HEIGHT = 320
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire  [S_TDATA_W-1:0]  s_axis_tdata_i,   // [14:0] run_length, [30:15] run_color
  input  wire                   s_axis_tlast_i,
  output logic                  m_axis_tvalid_o,
  input  wire                   m_axis_tready_i,
  output logic [M_TDATA_W-1:0]  m_axis_tdata_o,   // [8:0] span_x, [17:9] span_y,
                                                  // [26:18] span_length, [42:27] pixel_color
  output logic                  m_axis_tlast_o,
  input  wire                   cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire  [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire  [CFG_W-1:0]      cfg_data_i
);

  rrcs_cmd_t  cmd;
  rrcs_stat_t stat;

  assign cfg_ready_o = 1'b1;

  rrcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rrcs_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .run_length_i (s_axis_tdata_i[RUN_LEN_W-1:0]),
    .run_color_i  (s_axis_tdata_i[RUN_LEN_W+COLOR_W-1:RUN_LEN_W]),
    .last_run_i   (s_axis_tlast_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_data_o   (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule

`default_nettype wire
